>>> rtl/stereo_bbd_chorus_defines.svh
// ----------------------------------------------------------------------------
// stereo bbd chorus assertion macros
// shared concurrent check forms, clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef STEREO_BBD_CHORUS_DEFINES_SVH
`define STEREO_BBD_CHORUS_DEFINES_SVH

// same-cycle implication
`define SBC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbc_pkg
// types, constants, lookup tables and helpers of the stereo bbd chorus
// ----------------------------------------------------------------------------
package sbc_pkg;

    localparam int SMP_W       = 24;
    localparam int LANES       = 2;
    localparam int DELAY_DEPTH = 4096;
    localparam int DLY_AW      = $clog2(DELAY_DEPTH);
    localparam int SINE_DEPTH  = 1024;
    localparam int SINE_AW     = $clog2(SINE_DEPTH);
    localparam int TANH_STEPS  = 256;
    localparam int TANH_AW     = 9;
    localparam int TANH_W      = 31;
    localparam int TANH_SH     = SMP_W - 1 - 6;
    localparam int PHASE_W     = 24;
    localparam int PROD_W      = 30;
    localparam int MA_W        = 27;
    localparam int MB_W        = 25;
    localparam int CFG_AW      = 3;
    localparam int CFG_DW      = 23;

    localparam logic signed [31:0] SMP_MAX = 32'sd8388607;
    localparam logic signed [31:0] SMP_MIN = -32'sd8388608;

    localparam logic [31:0] EMPH_GAIN  = 32'd39322;
    localparam logic [31:0] BOOST_GAIN = 32'd75366;

    localparam logic [63:0] TANH_Q30_STEP = 64'd16775851;
    localparam logic [63:0] ONE_Q30       = 64'd1073741824;
    localparam logic [63:0] PI_Q30        = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q30   = 64'd1686629713;
    localparam logic [63:0] TWO_PI_Q30    = 64'd6746518852;

    typedef enum logic [CFG_AW-1:0] {
        CFG_LFO_STEP  = 3'd0,
        CFG_PRE_COEF  = 3'd1,
        CFG_DE_COEF   = 3'd2,
        CFG_BASE_DLY  = 3'd3,
        CFG_MOD_DEPTH = 3'd4,
        CFG_CROSS_AMT = 3'd5,
        CFG_CROSS_NRM = 3'd6,
        CFG_MONO      = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [22:0] lfo_phase_step;
        logic [15:0] pre_emph_coeff;
        logic [15:0] de_emph_coeff;
        logic [19:0] base_delay;
        logic [18:0] mod_depth;
        logic [15:0] cross_amount;
        logic [15:0] cross_norm;
        logic        mono_input;
    } cfg_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef enum logic [4:0] {
        STP_PRE_MUL,
        STP_PRE_UPD,
        STP_EMPH_MUL,
        STP_BOOST_MUL,
        STP_TANH_ADDR,
        STP_TANH_MUL,
        STP_TANH_OUT,
        STP_SINE_ADDR,
        STP_SINE_MUL,
        STP_LFO_MUL,
        STP_POS,
        STP_TAP_MUL,
        STP_TAP_ADD,
        STP_DE_MUL,
        STP_DE_UPD,
        STP_X_MUL,
        STP_N_MUL,
        STP_OUT
    } step_t;

    typedef struct packed {
        logic  load;
        logic  en;
        step_t step;
    } dp_cmd_t;

    typedef logic signed [SMP_W-1:0] sine_rom_t [SINE_DEPTH];
    typedef logic [TANH_W-1:0]       tanh_rom_t [TANH_STEPS+1];

    function automatic logic signed [SMP_W-1:0] sat_smp(input logic signed [31:0] v);
        logic signed [31:0] r;
        r = v;
        if (v > SMP_MAX)
        begin
            r = SMP_MAX;
        end
        else if (v < SMP_MIN)
        begin
            r = SMP_MIN;
        end
        return r[SMP_W-1:0];
    endfunction

    // restoring long division for the table build
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d})
            begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic sine_rom_t build_sine();
        sine_rom_t  rom;
        logic [63:0] a;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        logic        neg;
        for (int i = 0; i < SINE_DEPTH; i++)
        begin
            a   = 64'(i) * TWO_PI_Q30 / SINE_DEPTH;
            neg = 1'b0;
            if (a >= PI_Q30)
            begin
                neg = 1'b1;
                a   = a - PI_Q30;
            end
            if (a > HALF_PI_Q30)
            begin
                a = PI_Q30 - a;
            end
            term = a;
            sum  = a;
            for (int k = 1; k <= 6; k++)
            begin
                term = (((term * a) >> 30) * a) >> 30;
                case (k)
                    1:       term = term / 64'd6;
                    2:       term = term / 64'd20;
                    3:       term = term / 64'd42;
                    4:       term = term / 64'd72;
                    5:       term = term / 64'd110;
                    default: term = term / 64'd156;
                endcase
                if ((k % 2) == 1)
                begin
                    sum = sum - term;
                end
                else
                begin
                    sum = sum + term;
                end
            end
            v = (sum + 64'd64) >> 7;
            if (v > 64'd8388607)
            begin
                v = 64'd8388607;
            end
            rom[i] = neg ? -v[SMP_W-1:0] : v[SMP_W-1:0];
        end
        return rom;
    endfunction

    function automatic tanh_rom_t build_tanh();
        tanh_rom_t   rom;
        logic [63:0] t;
        logic [63:0] den;
        logic [63:0] nxt;
        rom[0] = '0;
        t      = 64'd0;
        for (int i = 0; i < TANH_STEPS; i++)
        begin
            den        = ONE_Q30 + ((t * TANH_Q30_STEP) >> 30);
            nxt        = udiv64(((t + TANH_Q30_STEP) << 30) + (den >> 1), den);
            rom[i + 1] = nxt[TANH_W-1:0];
            t          = nxt;
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine();
    localparam tanh_rom_t TANH_ROM = build_tanh();

endpackage

>>> rtl/sbc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbc channel interfaces
// valid/ready channels for the stereo input pair and the stereo output pair
// ----------------------------------------------------------------------------
interface sbc_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [sbc_pkg::SMP_W-1:0] left_in;
    logic signed [sbc_pkg::SMP_W-1:0] right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface sbc_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [sbc_pkg::SMP_W-1:0] left_out;
    logic signed [sbc_pkg::SMP_W-1:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

>>> rtl/sbc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbc_cfg
// configuration register file with reset defaults and indexed writes
// ----------------------------------------------------------------------------
module sbc_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [sbc_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [sbc_pkg::CFG_DW-1:0]    cfg_wdata,
    output sbc_pkg::cfg_t                 cfg
);

    sbc_pkg::cfg_t cfg_reg;
    sbc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (sbc_pkg::cfg_idx_t'(cfg_addr))
                sbc_pkg::CFG_LFO_STEP:  cfg_next.lfo_phase_step = cfg_wdata[22:0];
                sbc_pkg::CFG_PRE_COEF:  cfg_next.pre_emph_coeff = cfg_wdata[15:0];
                sbc_pkg::CFG_DE_COEF:   cfg_next.de_emph_coeff  = cfg_wdata[15:0];
                sbc_pkg::CFG_BASE_DLY:  cfg_next.base_delay     = cfg_wdata[19:0];
                sbc_pkg::CFG_MOD_DEPTH: cfg_next.mod_depth      = cfg_wdata[18:0];
                sbc_pkg::CFG_CROSS_AMT: cfg_next.cross_amount   = cfg_wdata[15:0];
                sbc_pkg::CFG_CROSS_NRM: cfg_next.cross_norm     = cfg_wdata[15:0];
                sbc_pkg::CFG_MONO:      cfg_next.mono_input     = cfg_wdata[0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lfo_phase_step <= 23'd1118;
            cfg_reg.pre_emph_coeff <= 16'd17980;
            cfg_reg.de_emph_coeff  <= 16'd41550;
            cfg_reg.base_delay     <= 20'd58982;
            cfg_reg.mod_depth      <= 19'd5603;
            cfg_reg.cross_amount   <= 16'd29491;
            cfg_reg.cross_norm     <= 16'd45198;
            cfg_reg.mono_input     <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/sbc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbc_ctrl
// sequencer that steps the datapath through one sample pair and owns the
// output valid flag
// ----------------------------------------------------------------------------
`include "stereo_bbd_chorus_defines.svh"

module sbc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output sbc_pkg::dp_cmd_t  cmd
);

    sbc_pkg::state_t state_reg;
    sbc_pkg::state_t state_next;
    sbc_pkg::step_t  step_reg;
    sbc_pkg::step_t  step_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sbc_pkg::ST_IDLE;
            step_reg      <= sbc_pkg::STP_PRE_MUL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        in_ready       = 1'b0;
        cmd.load       = 1'b0;
        cmd.en         = 1'b0;
        cmd.step       = step_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            sbc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sbc_pkg::ST_RUN;
                    step_next  = sbc_pkg::STP_PRE_MUL;
                end
            end
            sbc_pkg::ST_RUN:
            begin
                // last step waits for a free output register
                if (!(step_reg == sbc_pkg::STP_OUT && out_valid_reg && !out_ready))
                begin
                    cmd.en = 1'b1;
                    if (step_reg == sbc_pkg::STP_OUT)
                    begin
                        state_next     = sbc_pkg::ST_IDLE;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        step_next = sbc_pkg::step_t'(step_reg + 5'd1);
                    end
                end
            end
            default:
            begin
                state_next = sbc_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    `SBC_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_reg == sbc_pkg::ST_RUN && step_reg == sbc_pkg::STP_PRE_MUL, "accepted transaction did not start the sequence")
    `SBC_ASSERT_NOW(a_busy_blocks, state_reg == sbc_pkg::ST_RUN, !in_ready, "input taken while busy")
    `SBC_ASSERT_NOW(a_rise_after_out, $rose(out_valid_reg), $past(cmd.en && cmd.step == sbc_pkg::STP_OUT), "result shown without output step")

endmodule

>>> rtl/sbc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbc_dp
// two-lane datapath: one shared multiplier per lane, emphasis filters,
// tanh and sine tables, delay line memories, crossfeed and output registers
// ----------------------------------------------------------------------------
module sbc_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sbc_pkg::dp_cmd_t                 cmd,
    input  sbc_pkg::cfg_t                    cfg,
    input  logic signed [sbc_pkg::SMP_W-1:0] left_in,
    input  logic signed [sbc_pkg::SMP_W-1:0] right_in,
    output logic signed [sbc_pkg::SMP_W-1:0] left_out,
    output logic signed [sbc_pkg::SMP_W-1:0] right_out
);

    localparam int L = sbc_pkg::LANES;
    localparam int SW = sbc_pkg::SMP_W;
    localparam int AW = sbc_pkg::DLY_AW;

    // filter, phase and pointer state
    logic signed [SW-1:0]               pre_reg   [L];
    logic signed [SW-1:0]               de_reg    [L];
    logic [sbc_pkg::PHASE_W-1:0]        phase_reg [L];
    logic [AW-1:0]                      wp_reg;
    logic                               wrap_reg;

    // working registers
    logic signed [SW-1:0]               dry_reg   [L];
    logic signed [sbc_pkg::PROD_W-1:0]  prod_reg  [L];
    logic                               neg_reg   [L];
    logic [sbc_pkg::TANH_SH-1:0]        tfr_reg   [L];
    logic [sbc_pkg::TANH_W-1:0]         t0_reg    [L];
    logic [sbc_pkg::TANH_W-1:0]         t1_reg    [L];
    logic signed [SW-1:0]               s0_reg    [L];
    logic signed [SW-1:0]               s1_reg    [L];
    logic [sbc_pkg::PHASE_W-1:0]        sfr_reg   [L];
    logic signed [SW-1:0]               b0_reg    [L];
    logic signed [SW-1:0]               b1_reg    [L];
    logic                               v0_reg    [L];
    logic                               v1_reg    [L];
    logic [7:0]                         dfr_reg   [L];
    logic signed [SW+1:0]               w_reg     [L];
    logic signed [SW-1:0]               out_reg   [L];

    // delay line memories
    logic signed [SW-1:0]               dline_l [sbc_pkg::DELAY_DEPTH];
    logic signed [SW-1:0]               dline_r [sbc_pkg::DELAY_DEPTH];

    // combinational
    logic signed [31:0]                 a_w       [L];
    logic [31:0]                        b_w       [L];
    logic [4:0]                         sh        [L];
    logic                               is_mul;
    logic signed [sbc_pkg::MA_W+sbc_pkg::MB_W-1:0] mfull [L];
    logic signed [sbc_pkg::MA_W+sbc_pkg::MB_W-1:0] mshift [L];
    logic [sbc_pkg::PROD_W-1:0]         mag       [L];
    logic                               tclamp    [L];
    logic [sbc_pkg::TANH_AW-1:0]        ta0       [L];
    logic [sbc_pkg::TANH_AW-1:0]        ta1       [L];
    logic [31:0]                        ysum      [L];
    logic [31:0]                        yrnd      [L];
    logic signed [SW-1:0]               tval      [L];
    logic [sbc_pkg::SINE_AW-1:0]        sa0       [L];
    logic [sbc_pkg::SINE_AW-1:0]        sa1       [L];
    logic signed [31:0]                 dly       [L];
    logic signed [31:0]                 posw      [L];
    logic [AW-1:0]                      i0        [L];
    logic [AW-1:0]                      i1        [L];
    logic signed [SW-1:0]               bz0       [L];
    logic signed [SW-1:0]               bz1       [L];

    always_comb
    begin
        is_mul = 1'b0;
        case (cmd.step)
            sbc_pkg::STP_PRE_MUL, sbc_pkg::STP_EMPH_MUL, sbc_pkg::STP_BOOST_MUL,
            sbc_pkg::STP_TANH_MUL, sbc_pkg::STP_SINE_MUL, sbc_pkg::STP_LFO_MUL,
            sbc_pkg::STP_TAP_MUL, sbc_pkg::STP_DE_MUL, sbc_pkg::STP_X_MUL,
            sbc_pkg::STP_N_MUL:
                is_mul = 1'b1;
            default:
                is_mul = 1'b0;
        endcase
    end

    always_comb
    begin
        for (int c = 0; c < L; c++)
        begin
            bz0[c] = v0_reg[c] ? b0_reg[c] : '0;
            bz1[c] = v1_reg[c] ? b1_reg[c] : '0;

            a_w[c] = '0;
            b_w[c] = '0;
            sh[c]  = '0;
            case (cmd.step)
                sbc_pkg::STP_PRE_MUL:
                begin
                    a_w[c] = 32'(dry_reg[c]) - 32'(pre_reg[c]);
                    b_w[c] = 32'(cfg.pre_emph_coeff);
                    sh[c]  = 5'd16;
                end
                sbc_pkg::STP_EMPH_MUL:
                begin
                    a_w[c] = 32'(dry_reg[c]) - 32'(pre_reg[c]);
                    b_w[c] = sbc_pkg::EMPH_GAIN;
                    sh[c]  = 5'd16;
                end
                sbc_pkg::STP_BOOST_MUL:
                begin
                    a_w[c] = 32'(dry_reg[c]) + 32'(prod_reg[c]);
                    b_w[c] = sbc_pkg::BOOST_GAIN;
                    sh[c]  = 5'd16;
                end
                sbc_pkg::STP_TANH_MUL:
                begin
                    a_w[c] = $signed(32'(t1_reg[c]) - 32'(t0_reg[c]));
                    b_w[c] = 32'(tfr_reg[c]);
                    sh[c]  = 5'(sbc_pkg::TANH_SH);
                end
                sbc_pkg::STP_SINE_MUL:
                begin
                    a_w[c] = 32'(s1_reg[c]) - 32'(s0_reg[c]);
                    b_w[c] = 32'(sfr_reg[c]);
                    sh[c]  = 5'd24;
                end
                sbc_pkg::STP_LFO_MUL:
                begin
                    a_w[c] = 32'(s0_reg[c]) + 32'(prod_reg[c]);
                    b_w[c] = 32'(cfg.mod_depth);
                    sh[c]  = 5'd23;
                end
                sbc_pkg::STP_TAP_MUL:
                begin
                    a_w[c] = 32'(bz1[c]) - 32'(bz0[c]);
                    b_w[c] = 32'(dfr_reg[c]);
                    sh[c]  = 5'd8;
                end
                sbc_pkg::STP_DE_MUL:
                begin
                    a_w[c] = 32'(w_reg[c]) - 32'(de_reg[c]);
                    b_w[c] = 32'(cfg.de_emph_coeff);
                    sh[c]  = 5'd16;
                end
                sbc_pkg::STP_X_MUL:
                begin
                    a_w[c] = 32'(de_reg[L-1-c]);
                    b_w[c] = 32'(cfg.cross_amount);
                    sh[c]  = 5'd16;
                end
                sbc_pkg::STP_N_MUL:
                begin
                    a_w[c] = 32'(de_reg[c]) - 32'(prod_reg[c]);
                    b_w[c] = 32'(cfg.cross_norm);
                    sh[c]  = 5'd16;
                end
                default:
                begin
                    a_w[c] = '0;
                    b_w[c] = '0;
                    sh[c]  = '0;
                end
            endcase
            mfull[c]  = $signed(a_w[c][sbc_pkg::MA_W-1:0]) * $signed(b_w[c][sbc_pkg::MB_W-1:0]);
            mshift[c] = mfull[c] >>> sh[c];

            // saturator table lookup
            mag[c]    = prod_reg[c][sbc_pkg::PROD_W-1] ? sbc_pkg::PROD_W'(-prod_reg[c])
                                                       : sbc_pkg::PROD_W'(prod_reg[c]);
            tclamp[c] = |mag[c][sbc_pkg::PROD_W-1:sbc_pkg::TANH_SH+8];
            ta0[c]    = tclamp[c] ? sbc_pkg::TANH_AW'(sbc_pkg::TANH_STEPS)
                                  : {1'b0, mag[c][sbc_pkg::TANH_SH+7:sbc_pkg::TANH_SH]};
            ta1[c]    = tclamp[c] ? ta0[c] : ta0[c] + 1'b1;
            ysum[c]   = 32'(t0_reg[c]) + 32'(prod_reg[c]);
            yrnd[c]   = (ysum[c] + 32'd64) >> 7;
            if (yrnd[c] > 32'(sbc_pkg::SMP_MAX))
            begin
                yrnd[c] = 32'(sbc_pkg::SMP_MAX);
            end
            tval[c]   = neg_reg[c] ? -yrnd[c][SW-1:0] : yrnd[c][SW-1:0];

            // sine lookup
            sa0[c] = phase_reg[c][sbc_pkg::PHASE_W-1 -: sbc_pkg::SINE_AW];
            sa1[c] = sa0[c] + 1'b1;

            // tap position, wraps over the line length
            dly[c]  = $signed(32'(cfg.base_delay)) + 32'(prod_reg[c]);
            posw[c] = $signed(32'({wp_reg, 8'd0})) - dly[c];
            i0[c]   = posw[c][AW+7:8];
            i1[c]   = i0[c] + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < L; c++)
            begin
                pre_reg[c] <= '0;
                de_reg[c]  <= '0;
            end
            phase_reg[0] <= '0;
            phase_reg[1] <= 24'h800000;
            wp_reg       <= '0;
            wrap_reg     <= 1'b0;
        end
        else if (cmd.en)
        begin
            for (int c = 0; c < L; c++)
            begin
                case (cmd.step)
                    sbc_pkg::STP_PRE_UPD:
                        pre_reg[c] <= sbc_pkg::sat_smp(32'(pre_reg[c]) + 32'(prod_reg[c]));
                    sbc_pkg::STP_LFO_MUL:
                        phase_reg[c] <= phase_reg[c] + 24'(cfg.lfo_phase_step);
                    sbc_pkg::STP_DE_UPD:
                        de_reg[c] <= sbc_pkg::sat_smp(32'(de_reg[c]) + 32'(prod_reg[c]));
                    default:
                        pre_reg[c] <= pre_reg[c];
                endcase
            end
            if (cmd.step == sbc_pkg::STP_OUT)
            begin
                wp_reg <= wp_reg + 1'b1;
                if (&wp_reg)
                begin
                    wrap_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dry_reg[0] <= left_in;
            dry_reg[1] <= cfg.mono_input ? left_in : right_in;
        end
        if (cmd.en)
        begin
            for (int c = 0; c < L; c++)
            begin
                if (is_mul)
                begin
                    prod_reg[c] <= mshift[c][sbc_pkg::PROD_W-1:0];
                end
                case (cmd.step)
                    sbc_pkg::STP_TANH_ADDR:
                    begin
                        neg_reg[c] <= prod_reg[c][sbc_pkg::PROD_W-1];
                        tfr_reg[c] <= tclamp[c] ? '0 : mag[c][sbc_pkg::TANH_SH-1:0];
                        t0_reg[c]  <= sbc_pkg::TANH_ROM[ta0[c]];
                        t1_reg[c]  <= sbc_pkg::TANH_ROM[ta1[c]];
                    end
                    sbc_pkg::STP_SINE_ADDR:
                    begin
                        s0_reg[c]  <= sbc_pkg::SINE_ROM[sa0[c]];
                        s1_reg[c]  <= sbc_pkg::SINE_ROM[sa1[c]];
                        sfr_reg[c] <= {phase_reg[c][sbc_pkg::PHASE_W-sbc_pkg::SINE_AW-1:0],
                                       sbc_pkg::SINE_AW'(0)};
                    end
                    sbc_pkg::STP_POS:
                    begin
                        dfr_reg[c] <= posw[c][7:0];
                        v0_reg[c]  <= wrap_reg || (i0[c] <= wp_reg);
                        v1_reg[c]  <= wrap_reg || (i1[c] <= wp_reg);
                    end
                    sbc_pkg::STP_TAP_ADD:
                        w_reg[c] <= (SW+2)'(32'(bz0[c]) + 32'(prod_reg[c]));
                    sbc_pkg::STP_OUT:
                        out_reg[c] <= sbc_pkg::sat_smp(32'(dry_reg[c] >>> 1) + 32'(prod_reg[c]));
                    default:
                        neg_reg[c] <= neg_reg[c];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.en && cmd.step == sbc_pkg::STP_TANH_OUT)
        begin
            dline_l[wp_reg] <= tval[0];
        end
        if (cmd.en && cmd.step == sbc_pkg::STP_POS)
        begin
            b0_reg[0] <= dline_l[i0[0]];
            b1_reg[0] <= dline_l[i1[0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.en && cmd.step == sbc_pkg::STP_TANH_OUT)
        begin
            dline_r[wp_reg] <= tval[1];
        end
        if (cmd.en && cmd.step == sbc_pkg::STP_POS)
        begin
            b0_reg[1] <= dline_r[i0[1]];
            b1_reg[1] <= dline_r[i1[1]];
        end
    end

    assign left_out  = out_reg[0];
    assign right_out = out_reg[1];

endmodule

>>> rtl/stereo_bbd_chorus.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_bbd_chorus
// stereo chorus: pre-emphasis, boost, tanh saturation, sine-modulated
// interpolated delay, de-emphasis, crossfeed and half-level dry mix
//
//   channel   direction  payload               handshake
//   in_ch     sink       left_in, right_in     valid / ready
//   out_ch    source     left_out, right_out   valid / ready
//   cfg       sink       cfg_addr, cfg_wdata   cfg_we
//
// a transaction is accepted while idle and then runs 18 sequencer steps,
// set by the single multiplier each lane reuses for every product
// both channels run side by side in two lanes
// no clearing pass: unwritten delay entries read as zero through a wrap flag
// the result waits in the output register; the next input is taken meanwhile
// and the last step stalls only if the previous result is still not taken
// ----------------------------------------------------------------------------
module stereo_bbd_chorus (
    input  logic                          clk,
    input  logic                          rst_n,
    sbc_in_if.sink                        in_ch,
    sbc_out_if.source                     out_ch,
    input  logic                          cfg_we,
    input  logic [sbc_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [sbc_pkg::CFG_DW-1:0]    cfg_wdata
);

    sbc_pkg::cfg_t    cfg;
    sbc_pkg::dp_cmd_t cmd;

    sbc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    sbc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    sbc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg       (cfg),
        .left_in   (in_ch.left_in),
        .right_in  (in_ch.right_in),
        .left_out  (out_ch.left_out),
        .right_out (out_ch.right_out)
    );

endmodule
